[src/vadl_pkg.sv]
package vadl_pkg;

   localparam int SAMPLE_W = 16;
   localparam int LEN_IN_W = 17;
   localparam int GAIN_W   = 17;
   localparam int FRAC_W   = 16;
   localparam int PROD_W   = 34;
   localparam int SUM_W    = 19;

   localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd65536;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd32768;

   localparam logic signed [SUM_W-1:0] SUM_MAX = 19'sd32767;
   localparam logic signed [SUM_W-1:0] SUM_MIN = -19'sd32768;

   typedef enum logic [1:0] {
      MODE_ALLPASS = 2'd0,
      MODE_DELAY   = 2'd1,
      MODE_CLEAR   = 2'd2,
      MODE_NOP     = 2'd3
   } mode_type;

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > SUM_MAX) begin
         r = SUM_MAX[SAMPLE_W-1:0];
      end else if (v < SUM_MIN) begin
         r = SUM_MIN[SAMPLE_W-1:0];
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

[src/variable_allpass_delay_line_top.sv]
// Channel   Ports                                            Direction
// request   req_valid, req_stall, req_mode, req_sample_in,   in
//           req_delay_length
// response  rsp_valid, rsp_stall, rsp_sample_out             out
// config    csr_write_enable, csr_write_data                 in
//
// One word is processed at a time. An allpass word passes through the states ADDR,
// READ, SUM, MUL2, OUT, WAITMOD and DONE with its two gain multiplies; a plain delay
// word skips SUM, MUL2 and OUT. Whenever the next write position reaches the length,
// as at each wrap or after a shortened length, the remainder unit runs one bit a
// cycle and either kind of word then waits in WAITMOD until it is done. A clear
// word, and reset itself, sweeps the store one entry a cycle, all CAPACITY entries.
// The result register lets a new word be taken while a result is stalled.
module variable_allpass_delay_line_top #(
   parameter int CAPACITY = 65536
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_mode,
   input  logic signed [vadl_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic [vadl_pkg::LEN_IN_W-1:0]        req_delay_length,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [vadl_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic                                 csr_write_enable,
   input  logic [vadl_pkg::GAIN_W-1:0]          csr_write_data
);
   import vadl_pkg::*;

   localparam int ADDR_W  = $clog2(CAPACITY);
   localparam int LEN_W   = $clog2(CAPACITY + 1);
   localparam int CLAMP_W = (LEN_W > LEN_IN_W) ? LEN_W : LEN_IN_W;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADDR,
      ST_READ,
      ST_SUM,
      ST_MUL2,
      ST_OUT,
      ST_WAITMOD,
      ST_DONE
   } state_type;

   state_type                 state_ff;
   logic                      clr_reply_ff;
   logic [ADDR_W-1:0]         clr_addr_ff;
   logic [ADDR_W-1:0]         wp_ff;
   logic [GAIN_W-1:0]         gain_ff;
   mode_type                  mode_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic [LEN_W-1:0]          l_ff;
   logic signed [SAMPLE_W-1:0] d_ff;
   logic signed [SAMPLE_W-1:0] s_ff;
   logic signed [SAMPLE_W-1:0] y_ff;
   logic signed [PROD_W-1:0]  p_ff;
   logic                      rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_out_ff;

   logic [CLAMP_W-1:0]        len_wide;
   logic [LEN_W-1:0]          l_in;
   logic [LEN_W-1:0]          wp_ext;
   logic [LEN_W-1:0]          rd_pos;
   logic signed [SUM_W-1:0]   p_shifted;
   logic signed [SUM_W-1:0]   s_sum;
   logic signed [SUM_W-1:0]   y_sum;

   logic                      st_wr_en;
   logic [ADDR_W-1:0]         st_wr_addr;
   logic signed [SAMPLE_W-1:0] st_wr_data;
   logic                      st_rd_en;
   logic signed [SAMPLE_W-1:0] st_rd_data;
   logic                      mod_start;
   logic                      mod_valid;
   logic [LEN_W-1:0]          mod_rem;

   // Length zero counts as one; lengths beyond the store are held at its size.
   assign len_wide = CLAMP_W'(req_delay_length);
   always_comb begin
      if (len_wide == '0) begin
         l_in = LEN_W'(1);
      end else if (len_wide > CLAMP_W'(CAPACITY)) begin
         l_in = LEN_W'(CAPACITY);
      end else begin
         l_in = len_wide[LEN_W-1:0];
      end
   end

   assign wp_ext = LEN_W'(wp_ff);
   assign rd_pos = (wp_ext >= l_ff) ? (wp_ext - l_ff) : wp_ext;

   assign p_shifted = SUM_W'($signed(p_ff[PROD_W-1:FRAC_W]));
   assign s_sum     = SUM_W'(x_ff) + p_shifted;
   assign y_sum     = SUM_W'(d_ff) - p_shifted;

   always_comb begin
      st_wr_en   = 1'b0;
      st_wr_addr = wp_ff;
      st_wr_data = x_ff;
      case (state_ff)
         ST_CLEAR: begin
            st_wr_en   = 1'b1;
            st_wr_addr = clr_addr_ff;
            st_wr_data = '0;
         end
         ST_READ: begin
            st_wr_en = (mode_ff == MODE_DELAY);
         end
         ST_SUM: begin
            st_wr_en   = 1'b1;
            st_wr_data = sat_sample(s_sum);
         end
         default: begin
            st_wr_en = 1'b0;
         end
      endcase
   end

   assign st_rd_en  = (state_ff == ST_ADDR);
   assign mod_start = (state_ff == ST_ADDR);

   vadl_store #(
      .DEPTH (CAPACITY),
      .AW    (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (rd_pos[ADDR_W-1:0]),
      .rd_data (st_rd_data)
   );

   vadl_modulo #(
      .W (LEN_W)
   ) u_modulo (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .numerator (wp_ext + LEN_W'(1)),
      .divisor   (l_ff),
      .valid     (mod_valid),
      .remainder (mod_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_write_enable) begin
         gain_ff <= (csr_write_data > GAIN_ONE) ? GAIN_ONE : csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_reply_ff <= 1'b0;
         clr_addr_ff  <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (clr_addr_ff == ADDR_W'(CAPACITY - 1)) begin
                  clr_addr_ff <= '0;
                  state_ff    <= clr_reply_ff ? ST_DONE : ST_IDLE;
               end else begin
                  clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  mode_ff <= mode_type'(req_mode);
                  x_ff    <= req_sample_in;
                  l_ff    <= l_in;
                  y_ff    <= '0;
                  case (mode_type'(req_mode))
                     MODE_ALLPASS, MODE_DELAY: begin
                        state_ff <= ST_ADDR;
                     end
                     MODE_CLEAR: begin
                        clr_reply_ff <= 1'b1;
                        state_ff     <= ST_CLEAR;
                     end
                     default: begin
                        state_ff <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_ADDR: begin
               state_ff <= ST_READ;
            end
            ST_READ: begin
               d_ff <= st_rd_data;
               y_ff <= st_rd_data;
               p_ff <= PROD_W'(st_rd_data) * PROD_W'($signed({1'b0, gain_ff}));
               state_ff <= (mode_ff == MODE_DELAY) ? ST_WAITMOD : ST_SUM;
            end
            ST_SUM: begin
               s_ff     <= sat_sample(s_sum);
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               p_ff     <= PROD_W'(s_ff) * PROD_W'($signed({1'b0, gain_ff}));
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               y_ff     <= sat_sample(y_sum);
               state_ff <= ST_WAITMOD;
            end
            ST_WAITMOD: begin
               if (mod_valid) begin
                  wp_ff    <= mod_rem[ADDR_W-1:0];
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_sample_out_ff <= y_ff;
                  clr_reply_ff      <= 1'b0;
                  state_ff          <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;

`ifndef NO_ASSERTIONS
   a_wp_in_store: assert property (@(posedge clock) disable iff (reset)
      (LEN_W'(wp_ff) < LEN_W'(CAPACITY)))
      else $error("write position outside the store");

   a_wp_below_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAITMOD && mod_valid) |=> (LEN_W'(wp_ff) < l_ff))
      else $error("write position not wrapped below the length");

   a_store_write_states: assert property (@(posedge clock) disable iff (reset)
      st_wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_READ || state_ff == ST_SUM))
      else $error("store written outside a write state");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_sample_out_ff)))
      else $error("stalled result word overwritten");
`endif

endmodule

[src/vadl_store.sv]
module vadl_store #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [AW-1:0]                       wr_addr,
   input  logic signed [vadl_pkg::SAMPLE_W-1:0] wr_data,
   input  logic                                rd_en,
   input  logic [AW-1:0]                       rd_addr,
   output logic signed [vadl_pkg::SAMPLE_W-1:0] rd_data
);
   import vadl_pkg::*;

   logic signed [SAMPLE_W-1:0] mem [DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/vadl_modulo.sv]
module vadl_modulo #(
   parameter int W = 17
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] numerator,
   input  logic [W-1:0] divisor,
   output logic         valid,
   output logic [W-1:0] remainder
);
   localparam int CNT_W = $clog2(W + 1);

   logic             busy_ff;
   logic             valid_ff;
   logic [W-1:0]     num_ff;
   logic [W-1:0]     rem_ff;
   logic [W-1:0]     div_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [W:0]       trial;
   logic [W:0]       diff;

   // Restoring remainder, one numerator bit per cycle.
   assign trial = {rem_ff, num_ff[W-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else if (start) begin
         div_ff <= divisor;
         if (numerator < divisor) begin
            rem_ff   <= numerator;
            valid_ff <= 1'b1;
            busy_ff  <= 1'b0;
         end else begin
            num_ff   <= numerator;
            rem_ff   <= '0;
            cnt_ff   <= CNT_W'(W);
            valid_ff <= 1'b0;
            busy_ff  <= 1'b1;
         end
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_ff <= diff[W-1:0];
         end else begin
            rem_ff <= trial[W-1:0];
         end
         num_ff <= num_ff << 1;
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff  <= 1'b0;
            valid_ff <= 1'b1;
         end
      end
   end

   assign valid     = valid_ff;
   assign remainder = rem_ff;

`ifndef NO_ASSERTIONS
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !start) |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");
`endif

endmodule
